// File: design/osd_rle_palette_blitter_macros.svh
// Assertion macros shared by the blitter checker
`ifndef OSD_RLE_PALETTE_BLITTER_MACROS_SVH
`define OSD_RLE_PALETTE_BLITTER_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define OSDB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset
`define OSDB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/osdb_pkg.sv
// Types and constants of the run-length palette blitter
package osdb_pkg;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_PALETTE = 2'd1,
        REQ_BYTE    = 2'd2,
        REQ_PULL    = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        PH_LEN = 2'd0,
        PH_LOW = 2'd1,
        PH_IDX = 2'd2
    } parse_phase_t;

    localparam int CFG_AW = 4;

    localparam logic [1:0] REG_WINDOW_X      = 2'd0;
    localparam logic [1:0] REG_WINDOW_Y      = 2'd1;
    localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd2;
    localparam logic [1:0] REG_ELEMENT_COUNT = 2'd3;

    localparam logic [10:0] WINDOW_WIDTH_RESET = 11'd720;

    typedef struct packed {
        logic [10:0] window_x;
        logic [10:0] window_y;
        logic [10:0] window_width;
        logic [20:0] element_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic [7:0] palette_index;
        logic [7:0] palette_red;
        logic [7:0] palette_green;
        logic [7:0] palette_blue;
        logic [7:0] palette_alpha;
    } req_item_t;

    typedef struct packed {
        logic        accepted;
        logic        pixel_valid;
        logic [20:0] pixel_address;
        logic [31:0] pixel_color;
        logic        out_of_bounds;
        logic        image_done;
    } res_item_t;

    typedef struct packed {
        logic        wr_en;
        logic [7:0]  wr_addr;
        logic [31:0] wr_data;
        logic        rd_en;
        logic [7:0]  rd_addr;
    } pal_access_t;

endpackage

// File: design/osdb_if.sv
// Request and result channel interfaces
interface osdb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
    logic [7:0] palette_alpha;

    modport source (
        output valid, req_type, data_byte, palette_index,
               palette_red, palette_green, palette_blue, palette_alpha,
        input  ready
    );
    modport sink (
        input  valid, req_type, data_byte, palette_index,
               palette_red, palette_green, palette_blue, palette_alpha,
        output ready
    );
endinterface

interface osdb_res_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        pixel_valid;
    logic [20:0] pixel_address;
    logic [31:0] pixel_color;
    logic        out_of_bounds;
    logic        image_done;

    modport source (
        output valid, accepted, pixel_valid, pixel_address, pixel_color,
               out_of_bounds, image_done,
        input  ready
    );
    modport sink (
        input  valid, accepted, pixel_valid, pixel_address, pixel_color,
               out_of_bounds, image_done,
        output ready
    );
endinterface

// File: design/osdb_cfg.sv
// APB register file and precomputed window start addresses
module osdb_cfg #(
    parameter int FRAME_STRIDE = 1920,
    parameter int FRAME_ROWS   = 1080,
    parameter int ADDR_W       = 22
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [osdb_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output osdb_pkg::cfg_t            cfg,
    output logic [ADDR_W-1:0]         start_addr,
    output logic [ADDR_W-1:0]         start_wrap
);

    localparam int RAW_W = 11 + $clog2(FRAME_STRIDE) + 2;
    localparam logic [RAW_W-1:0] LIMIT_RAW = RAW_W'(FRAME_STRIDE * FRAME_ROWS);
    localparam logic [RAW_W-1:0] STRIDE_RAW = RAW_W'(FRAME_STRIDE);

    osdb_pkg::cfg_t     cfg_reg;
    logic [ADDR_W-1:0]  start_addr_reg;
    logic [ADDR_W-1:0]  start_wrap_reg;
    logic [RAW_W-1:0]   raw_addr;
    logic [RAW_W-1:0]   raw_wrap;
    logic               wr_en;
    logic [1:0]         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_x      <= '0;
            cfg_reg.window_y      <= '0;
            cfg_reg.window_width  <= osdb_pkg::WINDOW_WIDTH_RESET;
            cfg_reg.element_count <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                osdb_pkg::REG_WINDOW_X:      cfg_reg.window_x      <= pwdata[10:0];
                osdb_pkg::REG_WINDOW_Y:      cfg_reg.window_y      <= pwdata[10:0];
                osdb_pkg::REG_WINDOW_WIDTH:  cfg_reg.window_width  <= pwdata[10:0];
                osdb_pkg::REG_ELEMENT_COUNT: cfg_reg.element_count <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            osdb_pkg::REG_WINDOW_X:      prdata = {21'd0, cfg_reg.window_x};
            osdb_pkg::REG_WINDOW_Y:      prdata = {21'd0, cfg_reg.window_y};
            osdb_pkg::REG_WINDOW_WIDTH:  prdata = {21'd0, cfg_reg.window_width};
            osdb_pkg::REG_ELEMENT_COUNT: prdata = {11'd0, cfg_reg.element_count};
            default:                     prdata = '0;
        endcase
    end

    // start of window and start of its second row, both clamped to the frame end
    assign raw_addr = RAW_W'(cfg_reg.window_y) * STRIDE_RAW + RAW_W'(cfg_reg.window_x);
    assign raw_wrap = raw_addr + STRIDE_RAW;

    always_ff @(posedge clk)
    begin
        start_addr_reg <= (raw_addr > LIMIT_RAW) ? ADDR_W'(LIMIT_RAW) : ADDR_W'(raw_addr);
        start_wrap_reg <= (raw_wrap > LIMIT_RAW) ? ADDR_W'(LIMIT_RAW) : ADDR_W'(raw_wrap);
    end

    assign cfg        = cfg_reg;
    assign start_addr = start_addr_reg;
    assign start_wrap = start_wrap_reg;

endmodule

// File: design/osdb_palette.sv
// Palette colour memory, one write and one registered read port
module osdb_palette #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                  clk,
    input  osdb_pkg::pal_access_t acc,
    output logic [31:0]           rd_data
);

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    logic [31:0] mem [PALETTE_DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (acc.wr_en)
        begin
            mem[acc.wr_addr[PAL_AW-1:0]] <= acc.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc.rd_en)
        begin
            rd_data_reg <= mem[acc.rd_addr[PAL_AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/osdb_core.sv
// Request stage, run decoder, pixel address generator and result register
module osdb_core #(
    parameter int FRAME_STRIDE  = 1920,
    parameter int FRAME_ROWS    = 1080,
    parameter int PALETTE_DEPTH = 256,
    parameter int ADDR_W        = 22
) (
    input  logic                   clk,
    input  logic                   rst_n,
    osdb_req_if.sink               req,
    osdb_res_if.source             rsp,
    input  osdb_pkg::cfg_t         cfg,
    input  logic [ADDR_W-1:0]      start_addr,
    input  logic [ADDR_W-1:0]      start_wrap,
    output osdb_pkg::pal_access_t  pal_acc,
    input  logic [31:0]            pal_rd_data
);

    localparam logic [ADDR_W-1:0] LIMIT    = ADDR_W'(FRAME_STRIDE * FRAME_ROWS);
    localparam logic [ADDR_W:0]   LIMIT_X  = (ADDR_W+1)'(FRAME_STRIDE * FRAME_ROWS);
    localparam logic [ADDR_W:0]   STRIDE_X = (ADDR_W+1)'(FRAME_STRIDE);
    localparam logic [8:0]        DEPTH_X  = 9'(PALETTE_DEPTH);

    // request stage
    logic                  s1_valid_reg;
    osdb_pkg::req_item_t   s1_item_reg;
    logic                  s1_idx_ok_reg;

    // decoder state
    osdb_pkg::parse_phase_t phase_reg, phase_next;
    logic [14:0]           pend_reg, pend_next;
    logic [14:0]           run_reg, run_next;
    logic [31:0]           color_reg, color_next;
    logic [ADDR_W-1:0]     wa_reg, wa_next;
    logic [ADDR_W-1:0]     wrap_addr_reg, wrap_addr_next;
    logic [10:0]           col_reg, col_next;
    logic [20:0]           elem_reg, elem_next;

    // result stage
    logic                  out_valid_reg;
    osdb_pkg::res_item_t   out_reg;
    osdb_pkg::res_item_t   res;

    logic                  out_free;
    logic                  s1_go;
    logic                  accept;
    osdb_pkg::req_kind_t   kind_in;
    osdb_pkg::req_kind_t   kind;

    logic                  run_active;
    logic                  wrap_now;
    logic [ADDR_W:0]       wrap_sum;
    logic [ADDR_W-1:0]     wrap_step;
    logic [ADDR_W-1:0]     pix_addr;
    logic                  pix_oob;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_go     = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign accept    = req.valid && req.ready;
    assign kind_in   = osdb_pkg::req_kind_t'(req.req_type);
    assign kind      = osdb_pkg::req_kind_t'(s1_item_reg.req_type);

    // palette is written and read as the request is taken, so order is kept
    always_comb
    begin
        pal_acc.wr_en   = accept && (kind_in == osdb_pkg::REQ_PALETTE)
                          && ({1'b0, req.palette_index} < DEPTH_X);
        pal_acc.wr_addr = req.palette_index;
        pal_acc.wr_data = {req.palette_blue, req.palette_green,
                           req.palette_red, req.palette_alpha};
        pal_acc.rd_en   = accept && (kind_in == osdb_pkg::REQ_BYTE);
        pal_acc.rd_addr = req.data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.req_type      <= req.req_type;
            s1_item_reg.data_byte     <= req.data_byte;
            s1_item_reg.palette_index <= req.palette_index;
            s1_item_reg.palette_red   <= req.palette_red;
            s1_item_reg.palette_green <= req.palette_green;
            s1_item_reg.palette_blue  <= req.palette_blue;
            s1_item_reg.palette_alpha <= req.palette_alpha;
            s1_idx_ok_reg             <= {1'b0, req.data_byte} < DEPTH_X;
        end
    end

    // pixel address: on a wrap the next row start is already held in wrap_addr_reg
    assign run_active = run_reg != '0;
    assign wrap_now   = col_reg >= cfg.window_width;
    assign wrap_sum   = {1'b0, wrap_addr_reg} + STRIDE_X;
    assign wrap_step  = (wrap_sum > LIMIT_X) ? LIMIT : wrap_sum[ADDR_W-1:0];
    assign pix_addr   = (wrap_now && (wa_reg < LIMIT)) ? wrap_addr_reg : wa_reg;
    assign pix_oob    = pix_addr >= LIMIT;

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        pend_next      = pend_reg;
        run_next       = run_reg;
        color_next     = color_reg;
        wa_next        = wa_reg;
        wrap_addr_next = wrap_addr_reg;
        col_next       = col_reg;
        elem_next      = elem_reg;
        case (kind)
            osdb_pkg::REQ_START:
            begin
                phase_next     = osdb_pkg::PH_LEN;
                pend_next      = '0;
                run_next       = '0;
                color_next     = '0;
                wa_next        = start_addr;
                wrap_addr_next = start_wrap;
                col_next       = '0;
                elem_next      = cfg.element_count;
            end
            osdb_pkg::REQ_BYTE:
            begin
                if (!run_active && (elem_reg != '0))
                begin
                    case (phase_reg)
                        osdb_pkg::PH_LEN:
                        begin
                            if (s1_item_reg.data_byte[7])
                            begin
                                pend_next  = {s1_item_reg.data_byte[6:0], 8'h00};
                                phase_next = osdb_pkg::PH_LOW;
                            end
                            else
                            begin
                                pend_next  = {8'h00, s1_item_reg.data_byte[6:0]};
                                phase_next = osdb_pkg::PH_IDX;
                            end
                        end
                        osdb_pkg::PH_LOW:
                        begin
                            pend_next  = {pend_reg[14:8], s1_item_reg.data_byte};
                            phase_next = osdb_pkg::PH_IDX;
                        end
                        osdb_pkg::PH_IDX:
                        begin
                            color_next = s1_idx_ok_reg ? pal_rd_data : 32'd0;
                            run_next   = pend_reg;
                            elem_next  = elem_reg - 21'd1;
                            phase_next = osdb_pkg::PH_LEN;
                        end
                        default:
                        begin
                            phase_next = osdb_pkg::PH_LEN;
                        end
                    endcase
                end
            end
            osdb_pkg::REQ_PULL:
            begin
                if (run_active)
                begin
                    if (wrap_now)
                    begin
                        wrap_addr_next = wrap_step;
                    end
                    wa_next  = pix_oob ? pix_addr : pix_addr + 1'b1;
                    col_next = (wrap_now ? 11'd0 : col_reg) + 11'd1;
                    run_next = run_reg - 15'd1;
                end
            end
            default: ;
        endcase
    end

    // result of the request in the stage
    always_comb
    begin
        res.accepted      = 1'b1;
        res.pixel_valid   = 1'b0;
        res.pixel_address = '0;
        res.pixel_color   = '0;
        res.out_of_bounds = 1'b0;
        case (kind)
            osdb_pkg::REQ_BYTE:
            begin
                res.accepted = !run_active;
            end
            osdb_pkg::REQ_PULL:
            begin
                if (run_active)
                begin
                    res.out_of_bounds = pix_oob;
                    res.pixel_valid   = !pix_oob;
                    if (!pix_oob)
                    begin
                        res.pixel_address = 21'(pix_addr);
                        res.pixel_color   = color_reg;
                    end
                end
            end
            default: ;
        endcase
        res.image_done = (elem_next == '0) && (run_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= osdb_pkg::PH_LEN;
            pend_reg      <= '0;
            run_reg       <= '0;
            color_reg     <= '0;
            wa_reg        <= '0;
            wrap_addr_reg <= '0;
            col_reg       <= '0;
            elem_reg      <= '0;
        end
        else if (s1_go)
        begin
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            run_reg       <= run_next;
            color_reg     <= color_next;
            wa_reg        <= wa_next;
            wrap_addr_reg <= wrap_addr_next;
            col_reg       <= col_next;
            elem_reg      <= elem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.accepted      = out_reg.accepted;
    assign rsp.pixel_valid   = out_reg.pixel_valid;
    assign rsp.pixel_address = out_reg.pixel_address;
    assign rsp.pixel_color   = out_reg.pixel_color;
    assign rsp.out_of_bounds = out_reg.out_of_bounds;
    assign rsp.image_done    = out_reg.image_done;

endmodule

// File: design/osd_rle_palette_blitter.sv
// Top level of the run-length palette blitter
//
//  channel | direction | handshake          | carries
//  --------+-----------+--------------------+-------------------------------------
//  req     | in        | valid / ready      | request kind, stream byte, palette entry
//  rsp     | out       | valid / ready      | one result per request
//  apb     | in        | psel/penable/pready| window and element count registers
//
// One request per cycle sustained while results are taken; each request is registered
// in the request stage and then in the result register before its result appears.
// Palette writes and reads happen as a request is taken (one port each on the palette).
// A stalled result register holds the request stage; ready then falls.
// Reset clears the decoder state; the palette is undefined until written.
module osd_rle_palette_blitter #(
    parameter int FRAME_STRIDE  = 1920,
    parameter int FRAME_ROWS    = 1080,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    osdb_req_if.sink                    req,
    osdb_res_if.source                  rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [osdb_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int ADDR_W = $clog2(FRAME_STRIDE * FRAME_ROWS + 1);

    osdb_pkg::cfg_t        cfg;
    osdb_pkg::pal_access_t pal_acc;
    logic [31:0]           pal_rd_data;
    logic [ADDR_W-1:0]     start_addr;
    logic [ADDR_W-1:0]     start_wrap;

    osdb_cfg #(
        .FRAME_STRIDE (FRAME_STRIDE),
        .FRAME_ROWS   (FRAME_ROWS),
        .ADDR_W       (ADDR_W)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .start_addr (start_addr),
        .start_wrap (start_wrap)
    );

    osdb_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .acc     (pal_acc),
        .rd_data (pal_rd_data)
    );

    osdb_core #(
        .FRAME_STRIDE  (FRAME_STRIDE),
        .FRAME_ROWS    (FRAME_ROWS),
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .ADDR_W        (ADDR_W)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .start_addr  (start_addr),
        .start_wrap  (start_wrap),
        .pal_acc     (pal_acc),
        .pal_rd_data (pal_rd_data)
    );

endmodule

// File: design/osdb_checker.sv
// Port-level checks on the blitter result channel, bound to the top level
`include "osd_rle_palette_blitter_macros.svh"

module osdb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        accepted,
    input logic        pixel_valid,
    input logic [20:0] pixel_address,
    input logic [31:0] pixel_color,
    input logic        out_of_bounds,
    input logic        image_done
);

    `OSDB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

    `OSDB_ASSERT_NOW(a_idle_zero, rsp_valid && !pixel_valid, (pixel_address == 21'd0) && (pixel_color == 32'd0), "address or colour without a pixel")

    `OSDB_ASSERT_NOW(a_refused_quiet, rsp_valid && !accepted, !pixel_valid && !out_of_bounds && !image_done, "refused byte shows pixel activity")

    `OSDB_ASSERT_NOW(a_pixel_in_frame, rsp_valid && pixel_valid, accepted && !out_of_bounds, "pixel written while out of frame")

endmodule

bind osd_rle_palette_blitter osdb_checker u_osdb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .accepted      (rsp.accepted),
    .pixel_valid   (rsp.pixel_valid),
    .pixel_address (rsp.pixel_address),
    .pixel_color   (rsp.pixel_color),
    .out_of_bounds (rsp.out_of_bounds),
    .image_done    (rsp.image_done)
);

// File: bench/tb_osd_rle_palette_blitter.sv
`timescale 1ns / 100ps
// Self-checking bench for the run-length palette blitter: request driver, result monitor, predictor
module tb_osd_rle_palette_blitter;

    localparam int          STRIDE      = 1920;
    localparam int          ROWS        = 1080;
    localparam logic [21:0] FRAME_END   = 22'(STRIDE * ROWS);
    localparam int          QUIET_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 300;

    typedef struct {
        osdb_pkg::req_item_t request;
        osdb_pkg::res_item_t result;
    } job_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [osdb_pkg::CFG_AW-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    osdb_req_if req_ch ();
    osdb_res_if rsp_ch ();

    osd_rle_palette_blitter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block: registers and decoder state
    logic [10:0]            win_x      = '0;
    logic [10:0]            win_y      = '0;
    logic [10:0]            win_w      = osdb_pkg::WINDOW_WIDTH_RESET;
    logic [20:0]            elem_total = '0;
    logic [31:0]            palette [256];
    bit                     pal_known [256];
    int                     known_idx [$];
    osdb_pkg::parse_phase_t parse_at   = osdb_pkg::PH_LEN;
    logic [14:0]            len_acc    = '0;
    logic [14:0]            run_left   = '0;
    logic [31:0]            run_colour = '0;
    logic [21:0]            px_addr    = '0;
    logic [10:0]            col        = '0;
    logic [21:0]            elems_left = '0;

    job_t                request_queue [$];
    osdb_pkg::res_item_t pending_results [$];
    job_t                on_offer;
    bit                  offering = 1'b0;
    bit                  req_fire = 1'b0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int quiet         = 0;
    int items_done    = 0;
    int n_images      = 0;
    int n_results     = 0;
    int n_pixels      = 0;
    int n_offframe    = 0;
    int n_refused     = 0;
    int mismatches    = 0;

    function automatic logic [21:0] clip_to_frame(input logic [31:0] a);
        return (a > 32'(FRAME_END)) ? FRAME_END : a[21:0];
    endfunction

    // advances the shadow by one request and returns the result it must produce
    function automatic osdb_pkg::res_item_t decode_request(input osdb_pkg::req_item_t r);
        osdb_pkg::res_item_t o;
        o = '0;
        o.accepted = 1'b1;
        case (r.req_type)
            osdb_pkg::REQ_START:
            begin
                px_addr    = clip_to_frame(32'(win_y) * STRIDE + 32'(win_x));
                col        = '0;
                elems_left = 22'(elem_total);
                parse_at   = osdb_pkg::PH_LEN;
                len_acc    = '0;
                run_left   = '0;
                run_colour = '0;
            end
            osdb_pkg::REQ_PALETTE:
            begin
                palette[r.palette_index] = {r.palette_blue, r.palette_green,
                                            r.palette_red, r.palette_alpha};
                if (!pal_known[r.palette_index])
                begin
                    pal_known[r.palette_index] = 1'b1;
                    known_idx.push_back(int'(r.palette_index));
                end
            end
            osdb_pkg::REQ_BYTE:
            begin
                if (run_left != 0)
                    o.accepted = 1'b0;
                else if (elems_left != 0)
                begin
                    case (parse_at)
                        osdb_pkg::PH_LEN:
                        begin
                            if (r.data_byte[7])
                            begin
                                len_acc  = {r.data_byte[6:0], 8'h00};
                                parse_at = osdb_pkg::PH_LOW;
                            end
                            else
                            begin
                                len_acc  = 15'(r.data_byte);
                                parse_at = osdb_pkg::PH_IDX;
                            end
                        end
                        osdb_pkg::PH_LOW:
                        begin
                            len_acc  = len_acc | 15'(r.data_byte);
                            parse_at = osdb_pkg::PH_IDX;
                        end
                        default:
                        begin
                            run_colour = palette[r.data_byte];
                            run_left   = len_acc;
                            elems_left = elems_left - 1'b1;
                            parse_at   = osdb_pkg::PH_LEN;
                        end
                    endcase
                end
            end
            default:
            begin
                if (run_left != 0)
                begin
                    if (col >= win_w)
                    begin
                        // wrap to the window's left column one row down
                        if (px_addr < FRAME_END)
                            px_addr = clip_to_frame(32'(px_addr) - 32'(col) + STRIDE);
                        col = '0;
                    end
                    if (px_addr >= FRAME_END)
                        o.out_of_bounds = 1'b1;
                    else
                    begin
                        o.pixel_valid   = 1'b1;
                        o.pixel_address = px_addr[20:0];
                        o.pixel_color   = run_colour;
                        px_addr         = clip_to_frame(32'(px_addr) + 1);
                    end
                    col      = col + 1'b1;
                    run_left = run_left - 1'b1;
                end
            end
        endcase
        o.image_done = (elems_left == 0 && run_left == 0);
        return o;
    endfunction

    function automatic logic [7:0] known_colour();
        return 8'(known_idx[$urandom_range(0, known_idx.size() - 1)]);
    endfunction

    function automatic osdb_pkg::req_item_t rand_req(input osdb_pkg::req_kind_t kind);
        osdb_pkg::req_item_t r;
        r.req_type      = kind;
        r.data_byte     = 8'($urandom);
        r.palette_index = 8'($urandom);
        r.palette_red   = 8'($urandom);
        r.palette_green = 8'($urandom);
        r.palette_blue  = 8'($urandom);
        r.palette_alpha = 8'($urandom);
        return r;
    endfunction

    function automatic osdb_pkg::req_item_t byte_req(input logic [7:0] b);
        osdb_pkg::req_item_t r;
        r = rand_req(osdb_pkg::REQ_BYTE);
        r.data_byte = b;
        return r;
    endfunction

    function automatic osdb_pkg::req_item_t palette_req(input logic [7:0] idx,
                                                        input logic [7:0] red,
                                                        input logic [7:0] green,
                                                        input logic [7:0] blue,
                                                        input logic [7:0] alpha);
        osdb_pkg::req_item_t r;
        r = rand_req(osdb_pkg::REQ_PALETTE);
        r.palette_index = idx;
        r.palette_red   = red;
        r.palette_green = green;
        r.palette_blue  = blue;
        r.palette_alpha = alpha;
        return r;
    endfunction

    function automatic void queue_request(input osdb_pkg::req_item_t r);
        job_t j;
        // a byte taken as a run's colour index must name a loaded entry
        if (r.req_type == osdb_pkg::REQ_BYTE && run_left == 0 && elems_left != 0
            && parse_at == osdb_pkg::PH_IDX && !pal_known[r.data_byte])
            r.data_byte = known_colour();
        if (r.req_type == osdb_pkg::REQ_START)
            n_images++;
        j.request = r;
        j.result  = decode_request(r);
        if (j.result.accepted && (r.req_type != osdb_pkg::REQ_PULL || j.result.pixel_valid
                                  || j.result.out_of_bounds))
            items_done++;
        request_queue.push_back(j);
    endfunction

    // one image: start, then mostly well-formed elements with pulls, some noise
    function automatic void queue_image(input int n_elems);
        int sel;
        int len;
        int pulls;
        queue_request(rand_req(osdb_pkg::REQ_START));
        repeat ($urandom_range(0, 3))
            queue_request(rand_req(osdb_pkg::REQ_PALETTE));
        repeat (n_elems)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_request(rand_req(osdb_pkg::req_kind_t'($urandom_range(1, 3))));
            if ($urandom_range(0, 7) == 0)
                queue_request(rand_req(osdb_pkg::REQ_PALETTE));
            sel = $urandom_range(0, 99);
            if (sel < 8)
                len = 0;
            else if (sel < 90)
                len = $urandom_range(1, 12);
            else if (sel < 97)
                len = $urandom_range(13, 127);
            else
                len = $urandom_range(128, 260);
            if (len > 127 || $urandom_range(0, 5) == 0)
            begin
                queue_request(byte_req({1'b1, 7'(len >> 8)}));
                queue_request(byte_req(8'(len)));
            end
            else
                queue_request(byte_req({1'b0, 7'(len)}));
            queue_request(byte_req(known_colour()));
            pulls = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : len;
            repeat (pulls)
                queue_request(rand_req(osdb_pkg::REQ_PULL));
            if (run_left != 0)
                queue_request(rand_req(osdb_pkg::REQ_BYTE));
            // noise may have framed a huge length: restart rather than drain it
            if (run_left > 400)
                queue_request(rand_req(osdb_pkg::REQ_START));
            while (run_left != 0)
                queue_request(rand_req(osdb_pkg::REQ_PULL));
            if ($urandom_range(0, 9) == 0)
                queue_request(rand_req(osdb_pkg::REQ_PULL));
        end
        queue_request(rand_req(osdb_pkg::REQ_BYTE));
        queue_request(rand_req(osdb_pkg::REQ_PULL));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 50)
            $display("result %0d: %s is %h, expected %h", n_results, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            osdb_pkg::REG_WINDOW_X:      win_x = value[10:0];
            osdb_pkg::REG_WINDOW_Y:      win_y = value[10:0];
            osdb_pkg::REG_WINDOW_WIDTH:  win_w = value[10:0];
            osdb_pkg::REG_ELEMENT_COUNT: elem_total = value[20:0];
            default: ;
        endcase
    endtask

    task automatic set_window(input logic [10:0] x, input logic [10:0] y,
                              input logic [10:0] w, input logic [20:0] count);
        write_reg(osdb_pkg::REG_WINDOW_X, 32'(x));
        write_reg(osdb_pkg::REG_WINDOW_Y, 32'(y));
        write_reg(osdb_pkg::REG_WINDOW_WIDTH, 32'(w));
        write_reg(osdb_pkg::REG_ELEMENT_COUNT, 32'(count));
    endtask

    task automatic drain();
        while (request_queue.size() != 0 || offering || pending_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // request driver: holds an offer until taken, idles only between requests
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_fire)
                offering = 1'b0;
            if (!offering && request_queue.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                on_offer = request_queue.pop_front();
                offering = 1'b1;
            end
            req_ch.valid         <= offering;
            req_ch.req_type      <= on_offer.request.req_type;
            req_ch.data_byte     <= on_offer.request.data_byte;
            req_ch.palette_index <= on_offer.request.palette_index;
            req_ch.palette_red   <= on_offer.request.palette_red;
            req_ch.palette_green <= on_offer.request.palette_green;
            req_ch.palette_blue  <= on_offer.request.palette_blue;
            req_ch.palette_alpha <= on_offer.request.palette_alpha;
        end
    end

    // result receiver: long hold when asked, else random stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        osdb_pkg::res_item_t got;
        osdb_pkg::res_item_t want;
        bit                  res_fire;
        if (rst_n)
        begin
            req_fire = (req_ch.valid === 1'b1 && req_ch.ready === 1'b1);
            res_fire = (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1);
            if (req_fire)
                pending_results.push_back(on_offer.result);
            if (res_fire)
            begin
                got.accepted      = rsp_ch.accepted;
                got.pixel_valid   = rsp_ch.pixel_valid;
                got.pixel_address = rsp_ch.pixel_address;
                got.pixel_color   = rsp_ch.pixel_color;
                got.out_of_bounds = rsp_ch.out_of_bounds;
                got.image_done    = rsp_ch.image_done;
                if (pending_results.size() == 0)
                    report_mismatch("unrequested result, accepted", 32'(got.accepted), 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
                    if (got.pixel_valid !== want.pixel_valid)
                        report_mismatch("pixel_valid", 32'(got.pixel_valid),
                                        32'(want.pixel_valid));
                    if (got.pixel_address !== want.pixel_address)
                        report_mismatch("pixel_address", 32'(got.pixel_address),
                                        32'(want.pixel_address));
                    if (got.pixel_color !== want.pixel_color)
                        report_mismatch("pixel_color", got.pixel_color, want.pixel_color);
                    if (got.out_of_bounds !== want.out_of_bounds)
                        report_mismatch("out_of_bounds", 32'(got.out_of_bounds),
                                        32'(want.out_of_bounds));
                    if (got.image_done !== want.image_done)
                        report_mismatch("image_done", 32'(got.image_done),
                                        32'(want.image_done));
                    n_pixels   += want.pixel_valid;
                    n_offframe += want.out_of_bounds;
                    n_refused  += !want.accepted;
                end
                n_results++;
            end
            if (req_fire || res_fire)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("no request or result moved for %0d cycles", quiet);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          ph;
        int          n_elems;
        logic [10:0] x;
        logic [10:0] y;
        logic [10:0] w;
        logic [20:0] count;

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        on_offer.request     = '0;
        on_offer.result      = '0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = '0;
        req_ch.data_byte     = '0;
        req_ch.palette_index = '0;
        req_ch.palette_red   = '0;
        req_ch.palette_green = '0;
        req_ch.palette_blue  = '0;
        req_ch.palette_alpha = '0;
        rsp_ch.ready         = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: window on the last row, two pixels wide, so the third pixel leaves the frame
        set_window(11'd1917, 11'd1079, 11'd2, 21'd6);
        queue_request(palette_req(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_request(palette_req(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        queue_request(palette_req(8'h5A, 8'h12, 8'h34, 8'h56, 8'h78));
        queue_request(rand_req(osdb_pkg::REQ_PULL));
        queue_request(byte_req(8'h85));
        queue_request(rand_req(osdb_pkg::REQ_START));
        queue_request(byte_req(8'h03));
        queue_request(byte_req(8'hFF));
        queue_request(byte_req(8'h10));
        repeat (3)
            queue_request(rand_req(osdb_pkg::REQ_PULL));
        queue_request(byte_req(8'h00));
        queue_request(byte_req(8'h00));
        queue_request(byte_req(8'hFF));
        queue_request(byte_req(8'hFF));
        queue_request(byte_req(8'h5A));
        queue_request(rand_req(osdb_pkg::REQ_PULL));
        queue_request(palette_req(8'h5A, 8'hA5, 8'hC3, 8'h3C, 8'h81));
        queue_request(byte_req(8'h42));
        queue_request(rand_req(osdb_pkg::REQ_START));
        queue_request(rand_req(osdb_pkg::REQ_PULL));
        drain();

        for (ph = 0; items_done < 1700 || ph < 12; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 54;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 54;
                end
                default:
                begin
                    send_idle_pct = 15;
                    stall_pct     = 15;
                end
            endcase
            x     = 11'($urandom_range(0, 1919));
            y     = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(1075, 1079))
                                                : 11'($urandom_range(0, 1079));
            w     = 11'($urandom_range(1, 24));
            count = 21'($urandom_range(2, 8));
            case (ph % 6)
                0:
                begin
                    x = '0;
                    y = '0;
                    w = 11'd1;
                end
                1:
                begin
                    x = 11'd1919;
                    y = 11'd1079;
                    w = 11'd1920;
                end
                2:
                    w = '0;
                3:
                begin
                    // start beyond the frame
                    x = 11'h7FF;
                    y = 11'h7FF;
                    w = 11'h7FF;
                end
                default:
                    ;
            endcase
            if (ph == 3)
                count = '0;
            else if (ph == 7)
                count = 21'h1FFFFF;
            else if (ph == 9)
                count = 21'(STRIDE * ROWS);
            n_elems = (count > 10) ? 8 : int'(count) + ($urandom_range(0, 3) == 0);
            set_window(x, y, w, count);
            if (ph == 5)
                send_idle_pct = 0;
            queue_image(n_elems);
            if (ph == 5)
            begin
                // receiver holds off while requests keep coming
                @(posedge clk);
                hold_left = HOLD_CYCLES;
            end
            drain();
        end

        repeat (8)
            @(posedge clk);
        $display("%0d results over %0d image starts and %0d window settings", n_results,
                 n_images, ph + 1);
        $display("%0d pixels written, %0d off the frame, %0d bytes refused", n_pixels,
                 n_offframe, n_refused);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
